@@ rtl/stom_pkg.sv @@
// shared types, constants and codes for the space-time occupancy marker
`default_nettype none
package stom_pkg;

    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    localparam int GRID_T = 32;

    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int XBW   = $clog2(GRID_X + 1);
    localparam int YBW   = $clog2(GRID_Y + 1);
    localparam int CELLS = GRID_X * GRID_Y;
    localparam int AW    = $clog2(CELLS);
    localparam int ROW_W = 2 * GRID_T;
    localparam int KW    = (GRID_T > 1) ? $clog2(GRID_T) : 1;
    localparam int NSW   = 9;

    localparam int DIV_W = 26;
    localparam int DVS_W = 16;
    localparam int DCW   = $clog2(DIV_W);
    localparam int I0_W  = 28;
    localparam int N_W   = 17;

    typedef enum logic [2:0] {
        OP_CLEAR        = 3'd0,
        OP_STATIC_POINT = 3'd1,
        OP_TIMED_POINT  = 3'd2,
        OP_STATIC_BOX   = 3'd3,
        OP_TIMED_BOX    = 3'd4,
        OP_QUERY        = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SPACE = 2'd1;
    localparam logic [1:0] ST_TIME  = 2'd2;

    localparam logic [1:0] CV_FREE   = 2'd0;
    localparam logic [1:0] CV_STATIC = 2'd1;
    localparam logic [1:0] CV_TIMED  = 2'd2;

    localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] CFG_CELL_SIZE   = 3'd2;
    localparam logic [2:0] CFG_TIME_STEP   = 3'd3;
    localparam logic [2:0] CFG_TIME_SLICES = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_DIVT,
        S_DIVX,
        S_DIVY,
        S_DIVSX,
        S_DIVSY,
        S_SETUP,
        S_RD,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic             rem_nz;
    } t_div_res;

endpackage
`default_nettype wire

@@ rtl/stom_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module stom_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [stom_pkg::DIV_W-1:0]    i_dvd,
    input  wire [stom_pkg::DVS_W-1:0]    i_dvs,
    output stom_pkg::t_div_res           o_res
);
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [stom_pkg::DCW-1:0]    r_cnt, n_cnt;
    logic [stom_pkg::DIV_W-1:0]  r_quo, n_quo;
    logic [stom_pkg::DVS_W:0]    r_rem, n_rem;
    logic [stom_pkg::DVS_W-1:0]  r_dvs, n_dvs;
    logic [stom_pkg::DVS_W:0]    rem_sh;
    logic [stom_pkg::DVS_W+1:0]  diff;

    always_comb begin
        rem_sh = {r_rem[stom_pkg::DVS_W-1:0], r_quo[stom_pkg::DIV_W-1]};
        diff   = {1'b0, rem_sh} - (stom_pkg::DVS_W+2)'(r_dvs);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = stom_pkg::DCW'(stom_pkg::DIV_W - 1);
            n_quo  = i_dvd;
            n_rem  = '0;
            n_dvs  = i_dvs;
        end else if (r_busy) begin
            n_quo = {r_quo[stom_pkg::DIV_W-2:0], ~diff[stom_pkg::DVS_W+1]};
            n_rem = diff[stom_pkg::DVS_W+1] ? rem_sh : diff[stom_pkg::DVS_W:0];
            n_cnt = r_cnt - stom_pkg::DCW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_res.done   = r_done;
    assign o_res.quo    = r_quo;
    assign o_res.rem_nz = (r_rem != '0);
endmodule
`default_nettype wire

@@ rtl/stom_ram.sv @@
// single-port-write, registered-read row memory
`default_nettype none
module stom_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/space_time_occupancy_marker.sv @@
// top level: sequencer around a shared divider and the occupancy row memory
// each item runs up to 5 divides (fewer for points, queries and a time miss), a setup step,
// a read and a modify state per marked or queried cell and a done state that loads the result
// throughput: one item at a time, set by the shared divider and the read-modify-write loop
// a clear item sweeps the memory one row a cycle, all GRID_X*GRID_Y (4096) rows
// after reset the same clearing pass runs before the first item is taken
`default_nettype none
module space_time_occupancy_marker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [95:0] i_s_tdata,   // x_pos[23:0], y_pos[47:24], time_pos[63:48],
                                     // size_x[79:64], size_y[95:80]
    input  wire  [2:0]  i_s_tuser,   // operation[2:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // cell_value[1:0], zero fill above
    output logic [1:0]  o_m_tuser,   // status[1:0]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);
    localparam int XBW = stom_pkg::XBW;
    localparam int YBW = stom_pkg::YBW;
    localparam int XW  = stom_pkg::XW;
    localparam int YW  = stom_pkg::YW;
    localparam int AW  = stom_pkg::AW;
    localparam int KW  = stom_pkg::KW;
    localparam int IW  = stom_pkg::I0_W;
    localparam int NW  = stom_pkg::N_W;
    localparam int DW  = stom_pkg::DIV_W;

    stom_pkg::t_state r_state, n_state;

    logic signed [23:0] r_org_x, r_org_y;
    logic [15:0]        r_cs, r_ts;
    logic [5:0]         r_tsl;

    logic [2:0]         r_op, n_op;
    logic signed [23:0] r_x, n_x, r_y, n_y;
    logic [15:0]        r_tp, n_tp;
    logic signed [15:0] r_sx, n_sx, r_sy, n_sy;
    logic [KW-1:0]      r_k, n_k;
    logic signed [IW-1:0] r_i0, n_i0, r_j0, n_j0;
    logic [NW-1:0]      r_nx, n_nx, r_ny, n_ny;
    logic [XBW-1:0]     r_ia, n_ia, r_ib, n_ib;
    logic [YBW-1:0]     r_jb, n_jb;
    logic [XW-1:0]      r_i, n_i;
    logic [YW-1:0]      r_j, n_j;
    logic [1:0]         r_st, n_st, r_cv, n_cv;
    logic [AW-1:0]      r_clr_cnt, n_clr_cnt;
    logic               r_clr_resp, n_clr_resp;
    logic               r_div_go, n_div_go;
    logic               r_m_valid, n_m_valid;
    logic [1:0]         r_m_status, n_m_status, r_m_value, n_m_value;

    logic [15:0]        cs_eff, ts_eff;
    logic [stom_pkg::NSW-1:0] ns;
    logic               is_box, is_timed;
    logic signed [25:0] ax, ay;
    logic [DW-1:0]      dvd;
    logic               div_start;
    stom_pkg::t_div_res div_res;
    logic [DW:0]        q_ceil;
    logic signed [IW-1:0] q_neg, q_pos;
    logic signed [IW-1:0] ie, je, ia_s, ib_s, ja_s, jb_s;
    logic               empty, clipped;
    logic               i_last, j_last;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_addr;
    logic [stom_pkg::ROW_W-1:0] ram_wdata, ram_rdata, row_new;

    assign cs_eff   = (r_cs == '0) ? 16'd1 : r_cs;
    assign ts_eff   = (r_ts == '0) ? 16'd1 : r_ts;
    assign ns       = (stom_pkg::NSW'(r_tsl) < stom_pkg::NSW'(stom_pkg::GRID_T))
                      ? stom_pkg::NSW'(r_tsl) : stom_pkg::NSW'(stom_pkg::GRID_T);
    assign is_box   = (r_op == stom_pkg::OP_STATIC_BOX) || (r_op == stom_pkg::OP_TIMED_BOX);
    assign is_timed = (r_op == stom_pkg::OP_TIMED_POINT) || (r_op == stom_pkg::OP_TIMED_BOX)
                      || (r_op == stom_pkg::OP_QUERY);

    // corner relative to the origin; a negative extent moves the corner down
    assign ax = 26'(r_x) + ((is_box && r_sx < 0) ? 26'(r_sx) : 26'sd0) - 26'(r_org_x);
    assign ay = 26'(r_y) + ((is_box && r_sy < 0) ? 26'(r_sy) : 26'sd0) - 26'(r_org_y);

    stom_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (dvd),
        .i_dvs   ((r_state == stom_pkg::S_DIVT) ? ts_eff : cs_eff),
        .o_res   (div_res)
    );

    assign q_ceil = {1'b0, div_res.quo} + (DW+1)'(div_res.rem_nz);
    assign q_pos  = IW'(div_res.quo);
    assign q_neg  = -IW'(q_ceil);

    assign ie   = r_i0 + IW'(r_nx);
    assign je   = r_j0 + IW'(r_ny);
    assign ia_s = (r_i0 < 0) ? '0 : r_i0;
    assign ib_s = (ie > IW'(stom_pkg::GRID_X)) ? IW'(stom_pkg::GRID_X) : ie;
    assign ja_s = (r_j0 < 0) ? '0 : r_j0;
    assign jb_s = (je > IW'(stom_pkg::GRID_Y)) ? IW'(stom_pkg::GRID_Y) : je;
    assign empty   = (ia_s >= ib_s) || (ja_s >= jb_s);
    assign clipped = (r_i0 < 0) || (ie > IW'(stom_pkg::GRID_X))
                     || (r_j0 < 0) || (je > IW'(stom_pkg::GRID_Y));

    assign i_last = (XBW'(r_i) + XBW'(1) == r_ib);
    assign j_last = (YBW'(r_j) + YBW'(1) == r_jb);

    // divider operand and start, row update, memory write control and port outputs
    always_comb begin
        dvd = '0;
        unique case (r_state)
            stom_pkg::S_DIVT:  dvd = DW'(r_tp);
            stom_pkg::S_DIVX:  dvd = (ax < 0) ? DW'(-ax) : DW'(ax);
            stom_pkg::S_DIVY:  dvd = (ay < 0) ? DW'(-ay) : DW'(ay);
            stom_pkg::S_DIVSX: dvd = (r_sx < 0) ? DW'(-17'(r_sx)) : DW'(r_sx);
            stom_pkg::S_DIVSY: dvd = (r_sy < 0) ? DW'(-17'(r_sy)) : DW'(r_sy);
            default:           dvd = '0;
        endcase
        div_start = !r_div_go && ((r_state == stom_pkg::S_DIVT) || (r_state == stom_pkg::S_DIVX)
                    || (r_state == stom_pkg::S_DIVY) || (r_state == stom_pkg::S_DIVSX)
                    || (r_state == stom_pkg::S_DIVSY));

        for (int s = 0; s < stom_pkg::GRID_T; s++) begin
            if (is_timed) begin
                row_new[2*s +: 2] = (KW'(s) == r_k) ? stom_pkg::CV_TIMED : ram_rdata[2*s +: 2];
            end else begin
                row_new[2*s +: 2] = (stom_pkg::NSW'(s) < ns) ? stom_pkg::CV_STATIC
                                                             : ram_rdata[2*s +: 2];
            end
        end

        ram_addr  = AW'(AW'(r_j) * AW'(stom_pkg::GRID_X) + AW'(r_i));
        ram_we    = 1'b0;
        ram_waddr = ram_addr;
        ram_wdata = row_new;
        if (r_state == stom_pkg::S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = '0;
        end else if (r_state == stom_pkg::S_MOD && r_op != stom_pkg::OP_QUERY) begin
            ram_we = 1'b1;
        end

        o_s_tready  = (r_state == stom_pkg::S_IDLE);
        o_cfg_ready = 1'b1;
        o_m_tvalid  = r_m_valid;
        o_m_tdata   = {6'd0, r_m_value};
        o_m_tuser   = r_m_status;
    end

    stom_ram #(.DEPTH(stom_pkg::CELLS), .WIDTH(stom_pkg::ROW_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_x        = r_x;
        n_y        = r_y;
        n_tp       = r_tp;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_k        = r_k;
        n_i0       = r_i0;
        n_j0       = r_j0;
        n_nx       = r_nx;
        n_ny       = r_ny;
        n_ia       = r_ia;
        n_ib       = r_ib;
        n_jb       = r_jb;
        n_i        = r_i;
        n_j        = r_j;
        n_st       = r_st;
        n_cv       = r_cv;
        n_clr_cnt  = r_clr_cnt;
        n_clr_resp = r_clr_resp;
        n_div_go   = r_div_go;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_status = r_m_status;
        n_m_value  = r_m_value;

        if (div_start) begin
            n_div_go = 1'b1;
        end

        unique case (r_state)
            stom_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op  = i_s_tuser;
                    n_x   = i_s_tdata[23:0];
                    n_y   = i_s_tdata[47:24];
                    n_tp  = i_s_tdata[63:48];
                    n_sx  = i_s_tdata[79:64];
                    n_sy  = i_s_tdata[95:80];
                    n_st  = stom_pkg::ST_OK;
                    n_cv  = stom_pkg::CV_FREE;
                    n_div_go = 1'b0;
                    priority case (i_s_tuser)
                        stom_pkg::OP_CLEAR: begin
                            n_state    = stom_pkg::S_CLR;
                            n_clr_cnt  = '0;
                            n_clr_resp = 1'b1;
                        end
                        stom_pkg::OP_STATIC_POINT, stom_pkg::OP_STATIC_BOX:
                            n_state = stom_pkg::S_DIVX;
                        stom_pkg::OP_TIMED_POINT, stom_pkg::OP_TIMED_BOX, stom_pkg::OP_QUERY:
                            n_state = stom_pkg::S_DIVT;
                        default:
                            n_state = stom_pkg::S_DONE;
                    endcase
                end
            end
            stom_pkg::S_CLR: begin
                n_clr_cnt = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(stom_pkg::CELLS - 1)) begin
                    n_state    = r_clr_resp ? stom_pkg::S_DONE : stom_pkg::S_IDLE;
                    n_clr_resp = 1'b0;
                end
            end
            stom_pkg::S_DIVT: begin
                if (div_res.done) begin
                    n_div_go = 1'b0;
                    n_k      = div_res.quo[KW-1:0];
                    if (div_res.quo < DW'(ns)) begin
                        n_state = stom_pkg::S_DIVX;
                    end else begin
                        n_st    = stom_pkg::ST_TIME;
                        n_state = stom_pkg::S_DONE;
                    end
                end
            end
            stom_pkg::S_DIVX: begin
                if (div_res.done) begin
                    n_div_go = 1'b0;
                    n_i0     = (ax < 0) ? q_neg : q_pos;
                    n_state  = stom_pkg::S_DIVY;
                end
            end
            stom_pkg::S_DIVY: begin
                if (div_res.done) begin
                    n_div_go = 1'b0;
                    n_j0     = (ay < 0) ? q_neg : q_pos;
                    if (is_box) begin
                        n_state = stom_pkg::S_DIVSX;
                    end else begin
                        n_nx    = NW'(1);
                        n_ny    = NW'(1);
                        n_state = stom_pkg::S_SETUP;
                    end
                end
            end
            stom_pkg::S_DIVSX: begin
                if (div_res.done) begin
                    n_div_go = 1'b0;
                    n_nx     = NW'(q_ceil) + NW'(1);
                    n_state  = stom_pkg::S_DIVSY;
                end
            end
            stom_pkg::S_DIVSY: begin
                if (div_res.done) begin
                    n_div_go = 1'b0;
                    n_ny     = NW'(q_ceil) + NW'(1);
                    n_state  = stom_pkg::S_SETUP;
                end
            end
            stom_pkg::S_SETUP: begin
                n_st = clipped ? stom_pkg::ST_SPACE : stom_pkg::ST_OK;
                n_ia = XBW'(ia_s);
                n_ib = XBW'(ib_s);
                n_jb = YBW'(jb_s);
                n_i  = XW'(ia_s);
                n_j  = YW'(ja_s);
                n_state = empty ? stom_pkg::S_DONE : stom_pkg::S_RD;
            end
            stom_pkg::S_RD: begin
                n_state = stom_pkg::S_MOD;
            end
            stom_pkg::S_MOD: begin
                if (r_op == stom_pkg::OP_QUERY) begin
                    n_cv    = ram_rdata[2*r_k +: 2];
                    n_state = stom_pkg::S_DONE;
                end else if (i_last) begin
                    n_i = XW'(r_ia);
                    if (j_last) begin
                        n_state = stom_pkg::S_DONE;
                    end else begin
                        n_j     = r_j + YW'(1);
                        n_state = stom_pkg::S_RD;
                    end
                end else begin
                    n_i     = r_i + XW'(1);
                    n_state = stom_pkg::S_RD;
                end
            end
            stom_pkg::S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_st;
                    n_m_value  = r_cv;
                    n_state    = stom_pkg::S_IDLE;
                end
            end
            default: n_state = stom_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= stom_pkg::S_CLR;
            r_clr_cnt  <= '0;
            r_clr_resp <= 1'b0;
            r_div_go   <= 1'b0;
            r_m_valid  <= 1'b0;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_cs       <= 16'd256;
            r_ts       <= 16'd256;
            r_tsl      <= 6'd32;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_clr_resp <= n_clr_resp;
            r_div_go   <= n_div_go;
            r_m_valid  <= n_m_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    stom_pkg::CFG_ORIGIN_X:    r_org_x <= i_cfg_data;
                    stom_pkg::CFG_ORIGIN_Y:    r_org_y <= i_cfg_data;
                    stom_pkg::CFG_CELL_SIZE:   r_cs    <= i_cfg_data[15:0];
                    stom_pkg::CFG_TIME_STEP:   r_ts    <= i_cfg_data[15:0];
                    stom_pkg::CFG_TIME_SLICES: r_tsl   <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
        r_op       <= n_op;
        r_x        <= n_x;
        r_y        <= n_y;
        r_tp       <= n_tp;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_k        <= n_k;
        r_i0       <= n_i0;
        r_j0       <= n_j0;
        r_nx       <= n_nx;
        r_ny       <= n_ny;
        r_ia       <= n_ia;
        r_ib       <= n_ib;
        r_jb       <= n_jb;
        r_i        <= n_i;
        r_j        <= n_j;
        r_st       <= n_st;
        r_cv       <= n_cv;
        r_m_status <= n_m_status;
        r_m_value  <= n_m_value;
    end
endmodule
`default_nettype wire
